/* hdl/bsl_pkg.sv */
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared types, token kinds, character codes and byte-class helpers for the
// bracket string lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsl_pkg;

    // token kinds
    localparam logic [3:0] KIND_TEXT     = 4'd0;
    localparam logic [3:0] KIND_TEXT_END = 4'd1;
    localparam logic [3:0] KIND_LPAREN   = 4'd2;
    localparam logic [3:0] KIND_RPAREN   = 4'd3;
    localparam logic [3:0] KIND_LBRACK   = 4'd4;
    localparam logic [3:0] KIND_RBRACK   = 4'd5;
    localparam logic [3:0] KIND_LBRACE   = 4'd6;
    localparam logic [3:0] KIND_RBRACE   = 4'd7;
    localparam logic [3:0] KIND_EOI      = 4'd8;
    localparam logic [3:0] KIND_NONE     = 4'd0;   // bracket_kind: not a bracket

    // character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_LC_R   = 8'h72;

    // request queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] text_value;
        logic       quoted;
    } t_result;

    // one request: one or two results
    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_entry;

    function automatic logic [3:0] bracket_kind(input logic [7:0] b);
        logic [3:0] k;
        unique case (b)
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACK: k = KIND_LBRACK;
            CH_RBRACK: k = KIND_RBRACK;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic is_ws_between(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) ||
               (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic is_ws_ident(input logic [7:0] b);
        return is_ws_between(b) || (b == CH_FF);
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] b);
        logic [7:0] r;
        unique case (b)
            CH_LC_N: r = CH_LF;
            CH_LC_T: r = CH_TAB;
            CH_LC_V: r = CH_VT;
            CH_LC_R: r = CH_CR;
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/bracket_string_lexer.sv */
// ----------------------------------------------------------------------------
// bracket_string_lexer
// Byte-serial lexer for a bracketed list syntax with quoted strings.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one source byte per
//   request, or an end-of-input mark (i_end_of_input high, byte ignored).
//   Output channel (o_out_valid / i_out_ready) carries one token result per
//   request: kind, text_value, quoted, and last_of_run on the final result
//   that a source byte caused. A byte gives zero, one or two results.
//   Throughput: one byte per cycle. Results leave at one per cycle unless
//   stalled, so a two-result byte (bracket closing an identifier, end of
//   input inside a token) uses the output twice; the four-entry request
//   queue absorbs this and the input only stalls once the queue fills.
//   A result is written into the request queue at the edge that accepts
//   its byte and reaches the output when the output register loads it
//   from the queue head.
//   o_in_ready falls only when the request queue is full; a stalled receiver
//   therefore backs the input up after four pending requests plus the output
//   register and the second-result holding register.
//   Reset: lexer goes back between tokens, queue empties, output invalid.
//   No clearing pass; the block takes input as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_string_lexer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_input,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [3:0]      o_kind,
    output logic [7:0]      o_text_value,
    output logic            o_quoted,
    output logic            o_last_of_run
);
    import bsl_pkg::*;

    // front -> queue
    logic   w_push;
    t_entry w_push_entry;
    logic   w_q_full;
    // queue -> back
    logic   w_q_valid;
    t_entry w_q_entry;
    logic   w_pop;

    // front: mode tracking and byte classification
    bsl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .i_q_full       (w_q_full),
        .o_push         (w_push),
        .o_entry        (w_push_entry)
    );

    // decouples the input from output stalls
    bsl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    // back: splits requests into results, output register
    bsl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_entry     (w_q_entry),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_text_value  (o_text_value),
        .o_quoted      (o_quoted),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

/* hdl/bsl_front.sv */
// ----------------------------------------------------------------------------
// bsl_front
// Input side: takes source bytes, tracks lexer mode and builds the results of
// each byte that gives any as one queue request.
// ----------------------------------------------------------------------------
`default_nettype none

module bsl_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [7:0]      i_in_byte,
    input  wire logic            i_end_of_input,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output bsl_pkg::t_entry      o_entry
);
    import bsl_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_STRING = 2'd2,
        MODE_ESCAPE = 2'd3
    } t_mode_e;

    t_mode_e    r_mode, n_mode;
    logic       r_single, n_single;
    logic       w_accept;
    logic       w_has;
    logic [3:0] w_bk;
    logic [7:0] w_close;

    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_push     = w_accept && w_has;
    assign w_bk       = bracket_kind(i_in_byte);
    assign w_close    = r_single ? CH_SQUOTE : CH_DQUOTE;

    always_comb begin
        n_mode   = r_mode;
        n_single = r_single;
        w_has    = 1'b0;
        o_entry  = '0;
        if (i_end_of_input) begin
            w_has  = 1'b1;
            n_mode = MODE_IDLE;
            if (r_mode == MODE_IDENT || r_mode == MODE_STRING) begin
                o_entry.two          = 1'b1;
                o_entry.first.kind   = KIND_TEXT_END;
                o_entry.first.quoted = (r_mode == MODE_STRING);
                o_entry.second.kind  = KIND_EOI;
            end else begin
                o_entry.first.kind = KIND_EOI;
            end
        end else begin
            unique case (r_mode)
                MODE_IDLE: begin
                    if (w_bk != KIND_NONE) begin
                        w_has              = 1'b1;
                        o_entry.first.kind = w_bk;
                    end else if (i_in_byte == CH_DQUOTE || i_in_byte == CH_SQUOTE) begin
                        n_single = (i_in_byte == CH_SQUOTE);
                        n_mode   = MODE_STRING;
                    end else if (!is_ws_between(i_in_byte)) begin
                        w_has                    = 1'b1;
                        o_entry.first.kind       = KIND_TEXT;
                        o_entry.first.text_value = i_in_byte;
                        n_mode                   = MODE_IDENT;
                    end
                end
                MODE_IDENT: begin
                    w_has = 1'b1;
                    if (is_ws_ident(i_in_byte)) begin
                        o_entry.first.kind = KIND_TEXT_END;
                        n_mode             = MODE_IDLE;
                    end else if (w_bk != KIND_NONE) begin
                        o_entry.two         = 1'b1;
                        o_entry.first.kind  = KIND_TEXT_END;
                        o_entry.second.kind = w_bk;
                        n_mode              = MODE_IDLE;
                    end else begin
                        o_entry.first.kind       = KIND_TEXT;
                        o_entry.first.text_value = i_in_byte;
                    end
                end
                MODE_STRING: begin
                    if (i_in_byte == CH_BSLASH) begin
                        n_mode = MODE_ESCAPE;
                    end else if (i_in_byte == w_close) begin
                        w_has                = 1'b1;
                        o_entry.first.kind   = KIND_TEXT_END;
                        o_entry.first.quoted = 1'b1;
                        n_mode               = MODE_IDLE;
                    end else begin
                        w_has                    = 1'b1;
                        o_entry.first.kind       = KIND_TEXT;
                        o_entry.first.text_value = i_in_byte;
                        o_entry.first.quoted     = 1'b1;
                    end
                end
                MODE_ESCAPE: begin
                    w_has                    = 1'b1;
                    o_entry.first.kind       = KIND_TEXT;
                    o_entry.first.text_value = unescape(i_in_byte);
                    o_entry.first.quoted     = 1'b1;
                    n_mode                   = MODE_STRING;
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_single <= 1'b0;
        end else if (w_accept) begin
            r_mode   <= n_mode;
            r_single <= n_single;
        end
    end

endmodule

`default_nettype wire

/* hdl/bsl_queue.sv */
// ----------------------------------------------------------------------------
// bsl_queue
// Short FIFO of requests between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module bsl_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire bsl_pkg::t_entry i_entry,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output bsl_pkg::t_entry      o_entry
);
    import bsl_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;
    logic                w_push;
    logic                w_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/bsl_back.sv */
// ----------------------------------------------------------------------------
// bsl_back
// Output side: unpacks queue requests into single results and drives the
// registered output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bsl_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire bsl_pkg::t_entry i_q_entry,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [3:0]           o_kind,
    output logic [7:0]           o_text_value,
    output logic                 o_quoted,
    output logic                 o_last_of_run
);
    import bsl_pkg::*;

    logic    r_valid;
    t_result r_out;
    logic    r_last;
    logic    r_pend;       // second result of a two-result request waits
    t_result r_pend_res;
    logic    w_load;

    assign w_load = !r_valid || i_out_ready;
    assign o_pop  = w_load && !r_pend && i_q_valid;

    assign o_out_valid   = r_valid;
    assign o_kind        = r_out.kind;
    assign o_text_value  = r_out.text_value;
    assign o_quoted      = r_out.quoted;
    assign o_last_of_run = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (w_load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= i_q_valid;
                r_pend  <= i_q_valid && i_q_entry.two;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_pend) begin
                r_out  <= r_pend_res;
                r_last <= 1'b1;
            end else begin
                r_out      <= i_q_entry.first;
                r_last     <= !i_q_entry.two;
                r_pend_res <= i_q_entry.second;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/bsl_checker.sv */
// ----------------------------------------------------------------------------
// bsl_checker
// Port-level checks for the bracket string lexer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bsl_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       o_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [3:0] o_kind,
    input  wire logic [7:0] o_text_value,
    input  wire logic       o_quoted,
    input  wire logic       o_last_of_run
);
    import bsl_pkg::*;

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_kind) && $stable(o_text_value) &&
            $stable(o_quoted) && $stable(o_last_of_run))
        else $error("output changed while stalled");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind <= KIND_EOI))
        else $error("kind out of range");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != KIND_TEXT) |-> (o_text_value == 8'd0))
        else $error("text_value set on non-text result");

    a_quoted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != KIND_TEXT) && (o_kind != KIND_TEXT_END)
            |-> !o_quoted)
        else $error("quoted set on bracket or end result");

    // text bytes and end-of-input marks are always the last result of their byte
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_kind == KIND_TEXT) || (o_kind == KIND_EOI))
            |-> o_last_of_run)
        else $error("last_of_run missing");

endmodule

bind bracket_string_lexer bsl_checker u_bsl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_kind        (o_kind),
    .o_text_value  (o_text_value),
    .o_quoted      (o_quoted),
    .o_last_of_run (o_last_of_run)
);

`default_nettype wire
